// File: src/e2r_pkg.sv
// Package for the Euler angle to rotation matrix block.
// Holds CORDIC constants, the arctangent table and shared widths.
// No dependencies.
package e2r_pkg;

    localparam int ANG_W = 16;
    localparam int ELEM_W = 16;
    localparam int CW = 34;
    localparam int TRIG_W = 22;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [CW-1:0] ANG_PI = 34'sd3373259426;
    localparam logic signed [CW-1:0] ANG_HALF_PI = 34'sd1686629713;
    localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;

    typedef struct packed {
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
    } t_trig;

    function automatic logic signed [CW-1:0] atan_val(input int i);
        logic [31:0] v;
        begin
            case (i)
                0: v = 32'h3243F6A8;
                1: v = 32'h1DAC6705;
                2: v = 32'h0FADBAFC;
                3: v = 32'h07F56EA6;
                4: v = 32'h03FEAB76;
                5: v = 32'h01FFD55B;
                6: v = 32'h00FFFAAA;
                7: v = 32'h007FFF55;
                8: v = 32'h003FFFEA;
                9: v = 32'h001FFFFD;
                10: v = 32'h000FFFFF;
                11: v = 32'h0007FFFF;
                12: v = 32'h0003FFFF;
                13: v = 32'h0001FFFF;
                14: v = 32'h0000FFFF;
                15: v = 32'h00007FFF;
                16: v = 32'h00003FFF;
                17: v = 32'h00001FFF;
                18: v = 32'h00000FFF;
                19: v = 32'h000007FF;
                20: v = 32'h000003FF;
                21: v = 32'h000001FF;
                22: v = 32'h000000FF;
                23: v = 32'h0000007F;
                default: v = 32'h0;
            endcase
            atan_val = $signed({2'b00, v});
        end
    endfunction

endpackage

// File: src/euler_to_rotation_matrix.sv
// Euler angles (Q3.13) to Z-Y-X rotation matrix (Q1.14).
// The CORDIC stage count CORDIC_STAGES is capped at 24; one request per cycle.
// busy is always low; the CORDIC pipeline sets the latency.
// Reset clears the valid pipeline only; results cannot be stalled.
module euler_to_rotation_matrix #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_angle_x,
    input  logic signed [15:0] i_angle_y,
    input  logic signed [15:0] i_angle_z,
    output logic               o_valid,
    output logic signed [15:0] o_m00,
    output logic signed [15:0] o_m01,
    output logic signed [15:0] o_m02,
    output logic signed [15:0] o_m10,
    output logic signed [15:0] o_m11,
    output logic signed [15:0] o_m12,
    output logic signed [15:0] o_m20,
    output logic signed [15:0] o_m21,
    output logic signed [15:0] o_m22
);
    localparam int N = (CORDIC_STAGES < e2r_pkg::ATAN_ENTRIES) ?
        CORDIC_STAGES : e2r_pkg::ATAN_ENTRIES;
    localparam int LAT = N + 5;

    e2r_pkg::t_trig w_tx, w_ty, w_tz;
    logic signed [15:0] w_m [0:8];
    logic [LAT-1:0] r_vld;

    e2r_cordic #(.STAGES(CORDIC_STAGES)) u_cx (.i_clk, .i_angle(i_angle_x), .o_trig(w_tx));
    e2r_cordic #(.STAGES(CORDIC_STAGES)) u_cy (.i_clk, .i_angle(i_angle_y), .o_trig(w_ty));
    e2r_cordic #(.STAGES(CORDIC_STAGES)) u_cz (.i_clk, .i_angle(i_angle_z), .o_trig(w_tz));

    e2r_matrix u_mat (.i_clk, .i_tx(w_tx), .i_ty(w_ty), .i_tz(w_tz), .o_m(w_m));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start};
        end
    end

    assign busy = 1'b0;
    assign o_valid = r_vld[LAT-1];
    assign o_m00 = w_m[0];
    assign o_m01 = w_m[1];
    assign o_m02 = w_m[2];
    assign o_m10 = w_m[3];
    assign o_m11 = w_m[4];
    assign o_m12 = w_m[5];
    assign o_m20 = w_m[6];
    assign o_m21 = w_m[7];
    assign o_m22 = w_m[8];

`ifndef NO_ASSERTIONS
    a_no_busy: assert property (@(posedge i_clk) !busy)
        else $error("busy raised");
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_m20 <= 16'sd16384 && o_m20 >= -16'sd16384))
        else $error("element out of range");
`endif
endmodule

// File: src/e2r_cordic.sv
// Pipelined rotation-mode CORDIC giving sine and cosine of a Q3.13 angle.
// Uses e2r_pkg. An input register, the rotation stages and an output register.
module e2r_cordic #(
    parameter int STAGES = 16
) (
    input  logic                           i_clk,
    input  logic signed [e2r_pkg::ANG_W-1:0] i_angle,
    output e2r_pkg::t_trig                 o_trig
);
    localparam int CW = e2r_pkg::CW;
    localparam int N = (STAGES < e2r_pkg::ATAN_ENTRIES) ? STAGES : e2r_pkg::ATAN_ENTRIES;

    logic signed [CW-1:0] r_x [0:N];
    logic signed [CW-1:0] r_y [0:N];
    logic signed [CW-1:0] r_z [0:N];
    logic                 r_f [0:N];
    logic signed [CW-1:0] n_z;
    logic                 n_f;
    logic signed [CW-1:0] w_c;
    logic signed [CW-1:0] w_s;
    e2r_pkg::t_trig       r_trig;

    always_comb begin
        n_z = {{(CW-e2r_pkg::ANG_W-17){i_angle[e2r_pkg::ANG_W-1]}}, i_angle, 17'd0};
        n_f = 1'b0;
        if (n_z > e2r_pkg::ANG_HALF_PI) begin
            n_z = n_z - e2r_pkg::ANG_PI;
            n_f = 1'b1;
        end else if (n_z < -e2r_pkg::ANG_HALF_PI) begin
            n_z = n_z + e2r_pkg::ANG_PI;
            n_f = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0] <= e2r_pkg::INV_GAIN;
        r_y[0] <= '0;
        r_z[0] <= n_z;
        r_f[0] <= n_f;
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            r_f[i+1] <= r_f[i];
            if (!r_z[i][CW-1]) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - e2r_pkg::atan_val(i);
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + e2r_pkg::atan_val(i);
            end
        end
    end

    assign w_c = (r_f[N] ? -r_x[N] : r_x[N]) + CW'(512);
    assign w_s = (r_f[N] ? -r_y[N] : r_y[N]) + CW'(512);

    always_ff @(posedge i_clk) begin
        r_trig.c <= w_c[e2r_pkg::TRIG_W+9:10];
        r_trig.s <= w_s[e2r_pkg::TRIG_W+9:10];
    end

    assign o_trig = r_trig;
endmodule

// File: src/e2r_matrix.sv
// Three-stage product and sum pipeline forming the nine matrix elements.
// Uses e2r_pkg.
module e2r_matrix (
    input  logic                              i_clk,
    input  e2r_pkg::t_trig                    i_tx,
    input  e2r_pkg::t_trig                    i_ty,
    input  e2r_pkg::t_trig                    i_tz,
    output logic signed [e2r_pkg::ELEM_W-1:0] o_m [0:8]
);
    localparam int TW = e2r_pkg::TRIG_W;
    localparam int PW = 2 * TW;
    localparam int QW = 3 * TW + 2;
    localparam int ELEM_W_T = 16;

    logic signed [PW-1:0] r_czcy, r_szcy, r_cysx, r_cycx, r_czsy, r_szsy;
    logic signed [PW-1:0] r_szcx, r_szsx, r_czcx, r_czsx;
    logic signed [TW-1:0] r_sx, r_cx, r_sy;
    logic signed [QW-1:0] r_v [0:8];
    logic signed [ELEM_W_T-1:0] n_m [0:8];
    logic signed [ELEM_W_T-1:0] r_m [0:8];

    // The wide product is split into an upper and a lower half so that each
    // multiplier stays near the width of one trig value.
    function automatic logic signed [QW-1:0] mul3(input logic signed [PW-1:0] a,
                                                  input logic signed [TW-1:0] b);
        logic signed [TW-1:0] hi;
        logic signed [TW:0]   lo;
        logic signed [PW-1:0] ph;
        logic signed [PW:0]   pl;
        hi = a[PW-1:TW];
        lo = $signed({1'b0, a[TW-1:0]});
        ph = hi * b;
        pl = lo * b;
        mul3 = (QW'(ph) <<< TW) + QW'(pl);
    endfunction

    always_ff @(posedge i_clk) begin
        r_czcy <= i_tz.c * i_ty.c;
        r_szcy <= i_tz.s * i_ty.c;
        r_cysx <= i_ty.c * i_tx.s;
        r_cycx <= i_ty.c * i_tx.c;
        r_czsy <= i_tz.c * i_ty.s;
        r_szsy <= i_tz.s * i_ty.s;
        r_szcx <= i_tz.s * i_tx.c;
        r_szsx <= i_tz.s * i_tx.s;
        r_czcx <= i_tz.c * i_tx.c;
        r_czsx <= i_tz.c * i_tx.s;
        r_sx <= i_tx.s;
        r_cx <= i_tx.c;
        r_sy <= i_ty.s;
    end

    always_ff @(posedge i_clk) begin
        r_v[0] <= QW'(r_czcy) <<< 20;
        r_v[1] <= mul3(r_czsy, r_sx) - (QW'(r_szcx) <<< 20);
        r_v[2] <= mul3(r_czsy, r_cx) + (QW'(r_szsx) <<< 20);
        r_v[3] <= QW'(r_szcy) <<< 20;
        r_v[4] <= mul3(r_szsy, r_sx) + (QW'(r_czcx) <<< 20);
        r_v[5] <= mul3(r_szsy, r_cx) - (QW'(r_czsx) <<< 20);
        r_v[6] <= -(QW'(r_sy) <<< 40);
        r_v[7] <= QW'(r_cysx) <<< 20;
        r_v[8] <= QW'(r_cycx) <<< 20;
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            logic signed [QW-1:0] t;
            t = (r_v[k] + (QW'(1) <<< 45)) >>> 46;
            if (t > QW'(16384)) n_m[k] = 16'sd16384;
            else if (t < -QW'(16384)) n_m[k] = -16'sd16384;
            else n_m[k] = t[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_m <= n_m;
    end

    assign o_m = r_m;
endmodule

// File: tb/sv/tb_euler_to_rotation_matrix.sv
// Testbench for euler_to_rotation_matrix: drives angle triples, predicts each matrix
// with a bit-exact CORDIC model and checks every result in order. Depends on e2r_pkg.
`timescale 1ns / 1ps

class matrix_scoreboard;
    typedef struct {
        logic signed [15:0] m [9];
    } t_matrix;

    t_matrix pending[$];
    int errors;
    int stages;

    function new(int n_stages);
        errors = 0;
        stages = n_stages;
    endfunction

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void trig_of(logic signed [15:0] a, output longint s, output longint c);
        longint z, x, y, dx, dy, t;
        bit flip;
        z = longint'(a) * 131072;
        flip = 0;
        x = longint'(e2r_pkg::INV_GAIN);
        y = 0;
        if (z > longint'(e2r_pkg::ANG_HALF_PI)) begin
            z -= longint'(e2r_pkg::ANG_PI);
            flip = 1;
        end else if (z < -longint'(e2r_pkg::ANG_HALF_PI)) begin
            z += longint'(e2r_pkg::ANG_PI);
            flip = 1;
        end
        for (int i = 0; i < stages && i < 24; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            t = longint'(e2r_pkg::atan_val(i));
            if (z >= 0) begin
                x -= dx; y += dy; z -= t;
            end else begin
                x += dx; y -= dy; z += t;
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = floor_shift(x + 512, 10);
        s = floor_shift(y + 512, 10);
    endfunction

    function automatic logic signed [15:0] clamp_round(longint v, int s);
        longint r;
        r = floor_shift(v + (longint'(1) << (s - 1)), s);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    function automatic void note_request(logic signed [15:0] ax, logic signed [15:0] ay,
                                         logic signed [15:0] az);
        longint sx, cx, sy, cy, sz, cz, czsy, szsy;
        t_matrix e;
        trig_of(ax, sx, cx);
        trig_of(ay, sy, cy);
        trig_of(az, sz, cz);
        czsy = cz * sy;
        szsy = sz * sy;
        e.m[0] = clamp_round(cz * cy, 26);
        e.m[1] = clamp_round(czsy * sx - sz * cx * 1048576, 46);
        e.m[2] = clamp_round(czsy * cx + sz * sx * 1048576, 46);
        e.m[3] = clamp_round(sz * cy, 26);
        e.m[4] = clamp_round(szsy * sx + cz * cx * 1048576, 46);
        e.m[5] = clamp_round(szsy * cx - cz * sx * 1048576, 46);
        e.m[6] = clamp_round(-sy, 6);
        e.m[7] = clamp_round(cy * sx, 26);
        e.m[8] = clamp_round(cy * cx, 26);
        pending.push_back(e);
    endfunction

    function automatic void check_result(logic signed [15:0] got [9]);
        string names [9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};
        t_matrix e;
        if (pending.size() == 0) begin
            $error("unexpected result with no request waiting");
            errors++;
            return;
        end
        e = pending.pop_front();
        for (int k = 0; k < 9; k++)
            if (got[k] !== e.m[k]) begin
                $error("%s: expected %0d, actual %0d", names[k], e.m[k], got[k]);
                errors++;
            end
    endfunction
endclass

module tb_euler_to_rotation_matrix;
    localparam int STAGES = 16;
    localparam int LATENCY = STAGES + 5;
    localparam int N_RANDOM = 830;
    localparam longint CYCLE_LIMIT = 200000;

    logic i_clk, i_rst_n, start, busy, o_valid;
    logic signed [15:0] i_angle_x, i_angle_y, i_angle_z;
    logic signed [15:0] o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22;
    longint cycles = 0;
    matrix_scoreboard rotation_scb;

    euler_to_rotation_matrix #(.CORDIC_STAGES(STAGES)) dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0; start = 0;
        i_angle_x = 0; i_angle_y = 0; i_angle_z = 0;
        rotation_scb = new(STAGES);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_euler_to_rotation_matrix: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        logic signed [15:0] got [9];
        if (i_rst_n && o_valid) begin
            got = '{o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22};
            rotation_scb.check_result(got);
        end
        if (i_rst_n && start && !busy)
            rotation_scb.note_request(i_angle_x, i_angle_y, i_angle_z);
    end

    task automatic send_request(logic signed [15:0] ax, logic signed [15:0] ay,
                                logic signed [15:0] az, bit allow_gaps);
        int gap;
        if (allow_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 16);
            start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1;
        i_angle_x <= ax; i_angle_y <= ay; i_angle_z <= az;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return $signed(16'($urandom_range(0, 25736))) - 16'sd12868;
            2: return $signed(16'($urandom_range(12800, 12940)))
                      * ($urandom_range(0, 1) ? 16'sd1 : -16'sd1);
            default: return $signed(16'($urandom_range(0, 64))) - 16'sd32;
        endcase
    endfunction

    initial begin
        logic signed [15:0] edge_angles [10] = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd1, -16'sd1,
            16'sd12868, -16'sd12868, 16'sd12867, 16'sd25736, -16'sd25736};
        bit gaps;
        int drained;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (edge_angles[k])
            send_request(edge_angles[k], edge_angles[(k + 3) % 10], edge_angles[(k + 7) % 10], 0);
        send_request(16'sh5555, 16'shAAAA, 16'sh0F0F, 0);
        send_request(16'shAAAA, 16'sh5555, 16'shF0F0, 1);
        for (int n = 0; n < N_RANDOM; n++) begin
            gaps = n < N_RANDOM - 150;
            send_request(pick_angle(), pick_angle(), pick_angle(), gaps);
        end
        start <= 0;
        drained = 0;
        while (rotation_scb.pending.size() != 0 && drained < 10 * LATENCY) begin
            @(posedge i_clk);
            drained++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
        if (rotation_scb.errors == 0 && rotation_scb.pending.size() == 0) begin
            $display("tb_euler_to_rotation_matrix: done, clean");
        end else begin
            if (rotation_scb.pending.size() != 0)
                $error("%0d results never arrived", rotation_scb.pending.size());
            $display("tb_euler_to_rotation_matrix: done, errors");
        end
        $finish;
    end
endmodule
